>>> hdl/dfcm_pkg.sv
// Shared constants, types and register codes of the depth false colour mapper.
package dfcm_pkg;

  // Field widths.
  localparam int unsigned DepthW     = 16;
  localparam int unsigned ChanW      = 8;
  localparam int unsigned LimitW     = 13;
  localparam int unsigned LimitShift = 4;
  localparam int unsigned WinW       = LimitW + LimitShift;
  localparam int unsigned GreyW      = 16;

  // Pipeline shape: one setup stage, one stage per quotient bit, one output stage.
  localparam int unsigned DivSteps    = GreyW;
  localparam int unsigned NumStages   = DivSteps + 2;
  localparam int unsigned ColorStages = 4;

  // Colour ramp arithmetic. A ramp value is diff*25/859; the division by 859 is a
  // multiplication by ceil(2^28/859), exact for every operand below 2^28/326.
  localparam int unsigned DiffW      = 14;
  localparam int unsigned RampW      = 18;
  localparam int unsigned RampScale  = 25;
  localparam int unsigned RampRound  = 858;
  localparam int unsigned RampMul    = 312498;
  localparam int unsigned RampShift  = 28;
  localparam int unsigned RampProdW  = 37;
  localparam int unsigned RampQW     = 9;

  // Grey band: depth/510 as a multiplication by ceil(2^24/510), exact below 66052.
  localparam int unsigned GreyMul    = 32897;
  localparam int unsigned GreyShift  = 24;
  localparam int unsigned GreyProdW  = 29;
  localparam int unsigned GreyQW     = 5;

  localparam logic [ChanW-1:0] ChanMax = {ChanW{1'b1}};

  // Upper ends of the colour bands.
  localparam logic [DepthW-1:0] DepthBlackEnd = 16'd10;
  localparam logic [DepthW-1:0] DepthGreyEnd  = 16'd12794;
  localparam logic [DepthW-1:0] DepthRiseBEnd = 16'd21584;
  localparam logic [DepthW-1:0] DepthFallREnd = 16'd30374;
  localparam logic [DepthW-1:0] DepthRiseGEnd = 16'd39164;
  localparam logic [DepthW-1:0] DepthFallBEnd = 16'd47954;
  localparam logic [DepthW-1:0] DepthRiseREnd = 16'd56744;

  typedef enum logic [2:0] {
    BandBlack = 3'd0,
    BandGrey  = 3'd1,
    BandRiseB = 3'd2,
    BandFallR = 3'd3,
    BandRiseG = 3'd4,
    BandFallB = 3'd5,
    BandRiseR = 3'd6,
    BandFallG = 3'd7
  } band_e;

  // Configuration port.
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned RegIdxW  = 2;

  localparam logic [RegIdxW-1:0] RegNear   = 2'd0;
  localparam logic [RegIdxW-1:0] RegFar    = 2'd1;
  localparam logic [RegIdxW-1:0] RegEnable = 2'd2;

  localparam logic [LimitW-1:0] NearReset   = 13'd800;
  localparam logic [LimitW-1:0] FarReset    = 13'd8000;
  localparam logic              EnableReset = 1'b1;

  typedef struct packed {
    logic [LimitW-1:0] near_limit;
    logic [LimitW-1:0] far_limit;
    logic              window_enable;
  } cfg_t;

  typedef struct packed {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
    logic [GreyW-1:0] grey_value;
    logic             grey_valid;
  } pix_t;

endpackage

>>> hdl/dfcm_stream_if.sv
// Stream interfaces for depth input beats and false colour output beats.
interface dfcm_depth_if import dfcm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DepthW-1:0] depth_sample;

  modport source (output valid, output depth_sample, input ready);
  modport sink (input valid, input depth_sample, output ready);
endinterface

interface dfcm_pix_if import dfcm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] blue;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] red;
  logic [GreyW-1:0] grey_value;
  logic             grey_valid;

  modport source (output valid, output blue, output green, output red,
                  output grey_value, output grey_valid, input ready);
  modport sink (input valid, input blue, input green, input red,
                input grey_value, input grey_valid, output ready);
endinterface

>>> hdl/dfcm_cfg.sv
// APB register block holding the window bounds and the window enable.
module dfcm_cfg import dfcm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t               cfg_q;
  logic [RegIdxW-1:0] reg_idx;
  logic               wr_en;

  assign reg_idx = paddr[ApbAddrW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.near_limit    <= NearReset;
      cfg_q.far_limit     <= FarReset;
      cfg_q.window_enable <= EnableReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegNear:   cfg_q.near_limit    <= pwdata[LimitW-1:0];
        RegFar:    cfg_q.far_limit     <= pwdata[LimitW-1:0];
        RegEnable: cfg_q.window_enable <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegNear:   prdata = ApbDataW'(cfg_q.near_limit);
      RegFar:    prdata = ApbDataW'(cfg_q.far_limit);
      RegEnable: prdata = ApbDataW'(cfg_q.window_enable);
      default:   prdata = '0;
    endcase
  end

endmodule

>>> hdl/dfcm_color.sv
// Colour lane: band select, ramp scaling, reciprocal multiply, channel mux and delay line.
module dfcm_color import dfcm_pkg::*; (
  input  logic              clk_i,
  input  logic              adv_i,
  input  logic [DepthW-1:0] depth_i,
  output logic [ChanW-1:0]  blue_o,
  output logic [ChanW-1:0]  green_o,
  output logic [ChanW-1:0]  red_o
);

  typedef struct packed {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
  } bgr_t;

  band_e                s0_band_d, s0_band_q, s1_band_q, s2_band_q;
  logic [DiffW-1:0]     s0_diff_d, s0_diff_q, s1_diff_q;
  logic [RampW-1:0]     s1_x_d, s1_x_q;
  logic                 s1_fall;
  logic [RampProdW-1:0] ramp_prod;
  logic [GreyProdW-1:0] grey_prod;
  logic [RampQW-1:0]    s2_ramp_q;
  logic [GreyQW-1:0]    s2_grey_q;
  logic [ChanW-1:0]     rise, fall;
  bgr_t                 bgr_d;
  bgr_t                 bgr_q [ColorStages-1:NumStages-1];

  // Stage 0: find the band and the offset into it.
  always_comb begin
    priority if (depth_i < DepthBlackEnd) begin
      s0_band_d = BandBlack;
      s0_diff_d = '0;
    end else if (depth_i < DepthGreyEnd) begin
      s0_band_d = BandGrey;
      s0_diff_d = depth_i[DiffW-1:0];
    end else if (depth_i < DepthRiseBEnd) begin
      s0_band_d = BandRiseB;
      s0_diff_d = DiffW'(depth_i - DepthGreyEnd);
    end else if (depth_i < DepthFallREnd) begin
      s0_band_d = BandFallR;
      s0_diff_d = DiffW'(depth_i - DepthRiseBEnd);
    end else if (depth_i < DepthRiseGEnd) begin
      s0_band_d = BandRiseG;
      s0_diff_d = DiffW'(depth_i - DepthFallREnd);
    end else if (depth_i < DepthFallBEnd) begin
      s0_band_d = BandFallB;
      s0_diff_d = DiffW'(depth_i - DepthRiseGEnd);
    end else if (depth_i < DepthRiseREnd) begin
      s0_band_d = BandRiseR;
      s0_diff_d = DiffW'(depth_i - DepthFallBEnd);
    end else begin
      s0_band_d = BandFallG;
      s0_diff_d = DiffW'(depth_i - DepthRiseREnd);
    end
  end

  // Stage 1: scale by 25; a falling ramp adds 858 so the later floor becomes a ceiling.
  assign s1_fall = (s0_band_q == BandFallR) || (s0_band_q == BandFallB) ||
                   (s0_band_q == BandFallG);
  assign s1_x_d  = RampW'(s0_diff_q) * RampW'(RampScale) +
                   (s1_fall ? RampW'(RampRound) : RampW'(0));

  // Stage 2: reciprocal multiplications for the ramp and for the grey band.
  assign ramp_prod = RampProdW'(s1_x_q) * RampProdW'(RampMul);
  assign grey_prod = GreyProdW'(s1_diff_q) * GreyProdW'(GreyMul);

  // Stage 3: clamp the falling ramp and route the channels.
  assign rise = s2_ramp_q[ChanW-1:0];
  assign fall = (s2_ramp_q >= RampQW'(ChanMax)) ? '0 :
                ChanW'(RampQW'(ChanMax) - s2_ramp_q);

  always_comb begin
    unique case (s2_band_q)
      BandBlack: bgr_d = '{blue: '0, green: '0, red: '0};
      BandGrey:  bgr_d = '{blue: ChanW'(s2_grey_q), green: ChanW'(s2_grey_q),
                           red: ChanW'(s2_grey_q)};
      BandRiseB: bgr_d = '{blue: rise, green: '0, red: ChanMax};
      BandFallR: bgr_d = '{blue: ChanMax, green: '0, red: fall};
      BandRiseG: bgr_d = '{blue: ChanMax, green: rise, red: '0};
      BandFallB: bgr_d = '{blue: fall, green: ChanMax, red: '0};
      BandRiseR: bgr_d = '{blue: '0, green: ChanMax, red: rise};
      BandFallG: bgr_d = '{blue: '0, green: fall, red: ChanMax};
      default:   bgr_d = '{blue: '0, green: '0, red: '0};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s0_band_q <= s0_band_d;
      s0_diff_q <= s0_diff_d;
      s1_band_q <= s0_band_q;
      s1_diff_q <= s0_diff_q;
      s1_x_q    <= s1_x_d;
      s2_band_q <= s1_band_q;
      s2_ramp_q <= ramp_prod[RampShift +: RampQW];
      s2_grey_q <= grey_prod[GreyShift +: GreyQW];
      bgr_q[ColorStages-1] <= bgr_d;
    end
  end

  // Delay line that keeps the colour in step with the grey divider.
  for (genvar s = ColorStages; s < NumStages; s++) begin : g_delay
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        bgr_q[s] <= bgr_q[s-1];
      end
    end
  end

  assign blue_o  = bgr_q[NumStages-1].blue;
  assign green_o = bgr_q[NumStages-1].green;
  assign red_o   = bgr_q[NumStages-1].red;

endmodule

>>> hdl/dfcm_grey.sv
// Grey lane: window check and a pipelined restoring divider, one quotient bit per stage.
module dfcm_grey import dfcm_pkg::*; (
  input  logic              clk_i,
  input  logic              adv_i,
  input  logic [DepthW-1:0] depth_i,
  input  cfg_t              cfg_i,
  output logic [GreyW-1:0]  grey_value_o,
  output logic              grey_valid_o
);

  typedef struct packed {
    logic             en;
    logic             hit;
    logic             top;
    logic [WinW-1:0]  rem;
    logic [WinW-1:0]  den;
    logic [GreyW-1:0] quo;
  } div_t;

  div_t             div_q [DivSteps+1];
  div_t             setup_d;
  logic [WinW-1:0]  lo, hi, depth_w;
  logic [GreyW-1:0] grey_q;
  logic             valid_q;

  // One restoring step: shift the partial remainder and subtract the divisor if it fits.
  function automatic div_t div_step(div_t cur);
    div_t          nxt;
    logic [WinW:0] trial;
    logic          fits;
    nxt   = cur;
    trial = {cur.rem, 1'b0};
    fits  = trial >= {1'b0, cur.den};
    nxt.rem = fits ? WinW'(trial - {1'b0, cur.den}) : WinW'(trial);
    nxt.quo = {cur.quo[GreyW-2:0], fits};
    return nxt;
  endfunction

  assign lo      = {cfg_i.near_limit, {LimitShift{1'b0}}};
  assign hi      = {cfg_i.far_limit, {LimitShift{1'b0}}};
  assign depth_w = WinW'(depth_i);

  // Inside the window and below its far end the offset is below the span, so the
  // quotient 65536*offset/span fits in sixteen bits; at the far end it saturates.
  always_comb begin
    setup_d.en  = cfg_i.window_enable;
    setup_d.hit = (depth_w >= lo) && (depth_w <= hi);
    setup_d.top = (depth_w == hi);
    setup_d.rem = depth_w - lo;
    setup_d.den = hi - lo;
    setup_d.quo = '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      div_q[0] <= setup_d;
    end
  end

  for (genvar k = 1; k <= DivSteps; k++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        div_q[k] <= div_step(div_q[k-1]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      valid_q <= div_q[DivSteps].en;
      if (!(div_q[DivSteps].en && div_q[DivSteps].hit)) begin
        grey_q <= '0;
      end else if (div_q[DivSteps].top) begin
        grey_q <= '1;
      end else begin
        grey_q <= div_q[DivSteps].quo;
      end
    end
  end

  assign grey_value_o = grey_q;
  assign grey_valid_o = valid_q;

endmodule

>>> hdl/dfcm_outbuf.sv
// Two-entry output buffer: output register plus skid register, so input ready is registered.
module dfcm_outbuf import dfcm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  pix_t       pix_i,
  output logic       room_o,
  dfcm_pix_if.source pix_o
);

  pix_t out_q, skid_q;
  logic out_valid_q, skid_valid_q;
  logic pop;

  assign pop    = out_valid_q && pix_o.ready;
  assign room_o = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      priority if (push_i && pop) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q  <= skid_valid_q;
        skid_valid_q <= 1'b0;
      end else if (push_i) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= out_valid_q;
      end else begin
        // Nothing moves; both entries keep their state.
      end
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (push_i && pop) begin
      out_q  <= skid_valid_q ? skid_q : pix_i;
      skid_q <= pix_i;
    end else if (pop) begin
      out_q <= skid_q;
    end else if (push_i) begin
      if (out_valid_q) begin
        skid_q <= pix_i;
      end else begin
        out_q <= pix_i;
      end
    end else begin
      // Nothing moves; both entries keep their data.
    end
  end

  assign pix_o.valid      = out_valid_q;
  assign pix_o.blue       = out_q.blue;
  assign pix_o.green      = out_q.green;
  assign pix_o.red        = out_q.red;
  assign pix_o.grey_value = out_q.grey_value;
  assign pix_o.grey_valid = out_q.grey_valid;

  // The skid register only ever holds a beat behind an occupied output register.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a beat while the output register is empty");

  // The skid register fills only when the output beat was held back.
  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !pix_o.ready))
    else $error("skid register filled without a stalled output beat");

endmodule

>>> hdl/depth_false_color_mapper.sv
// Top level of the depth false colour mapper: pipeline control, lanes and register port.
//
//   Channel   Direction  Beat contents                                   Handshake
//   depth_i   in         depth_sample[15:0]                              valid/ready
//   pix_o     out        blue, green, red [7:0], grey_value[15:0],       valid/ready
//                        grey_valid
//   APB       in/out     near_limit @0x0, far_limit @0x4,                psel/penable
//                        window_enable @0x8
//
// One pixel enters per clock while the skid register is free. The pipeline length, and so the
// delay to the output, is set by the grey divider, which produces one quotient bit per stage.
// Reset clears the stage valid bits and the output buffer and loads the register defaults.
// The pipeline moves as a whole; it halts only while the skid register is occupied.
module depth_false_color_mapper import dfcm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  dfcm_depth_if.sink          depth_i,
  dfcm_pix_if.source          pix_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  cfg_t                 cfg;
  logic                 adv;
  logic [NumStages-1:0] valid_q;
  pix_t                 pix_tail;

  // Register file. Writes must arrive only while no pixel is in flight; the block itself does
  // not enforce this. The grey lane reads the live settings in its setup stage.
  dfcm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The whole pipeline advances together whenever the output buffer has a free slot.
  // The buffer's room signal is a register, so the input ready never depends on the
  // output ready within the same cycle.
  assign depth_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[NumStages-2:0], depth_i.valid};
    end
  end

  // Colour lane: four working stages followed by a delay line to the last stage.
  dfcm_color u_color (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .depth_i (depth_i.depth_sample),
    .blue_o  (pix_tail.blue),
    .green_o (pix_tail.green),
    .red_o   (pix_tail.red)
  );

  // Grey lane: window setup, sixteen divide steps and a final saturate stage.
  dfcm_grey u_grey (
    .clk_i        (clk_i),
    .adv_i        (adv),
    .depth_i      (depth_i.depth_sample),
    .cfg_i        (cfg),
    .grey_value_o (pix_tail.grey_value),
    .grey_valid_o (pix_tail.grey_valid)
  );

  // The last pipeline stage hands its beat to the output buffer whenever it advances.
  dfcm_outbuf u_outbuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (adv && valid_q[NumStages-1]),
    .pix_i  (pix_tail),
    .room_o (adv),
    .pix_o  (pix_o)
  );

  // With nothing waiting at the output the block must be able to take a pixel.
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_o.valid |-> depth_i.ready)
    else $error("input not ready although the output is empty");

  // A grey value is only ever non-zero when the window output was computed.
  a_grey_zero_when_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_o.valid && !pix_o.grey_valid) |-> (pix_o.grey_value == '0))
    else $error("grey value set while the window output is off");

  // While the pipeline is halted its occupancy does not change.
  a_halt_holds_stages: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(valid_q) || $past(adv) == 1'b0 && valid_q == $past(valid_q))
    else $error("pipeline stages changed while halted");

endmodule
